FILE: rtl/nor_flash_command_interface_unit_macros.svh
// ---------------------------------------------------------------------------
// NOR flash command interface assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef NOR_FLASH_COMMAND_INTERFACE_UNIT_MACROS_SVH
`define NOR_FLASH_COMMAND_INTERFACE_UNIT_MACROS_SVH

// Same-cycle implication.
`define NFCI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define NFCI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/nfci_pkg.sv
// ---------------------------------------------------------------------------
// NOR flash command interface package
// Sizes, command codes, decoder phases and shared structs.
// ---------------------------------------------------------------------------
package nfci_pkg;

	// Array geometry.
	localparam int ADDR_BITS        = 20;
	localparam int SECTOR_BITS      = 16;
	localparam int UNLOCK_ADDR_BITS = 11;
	localparam int ADDR_W           = ADDR_BITS;
	localparam int UA_W             = UNLOCK_ADDR_BITS;
	localparam int ARRAY_WORDS      = 1 << ADDR_BITS;

	// Low word-offset bits inside one sector.
	localparam logic [ADDR_W-1:0] SECT_LOW_MASK =
		ADDR_W'((64'd1 << SECTOR_BITS) - 64'd1);

	// Bus access kinds.
	localparam logic ACC_READ  = 1'b0;
	localparam logic ACC_WRITE = 1'b1;

	// Command codes, compared on the low byte of the write word.
	localparam logic [7:0] FC_UNLOCK1  = 8'hAA;
	localparam logic [7:0] FC_UNLOCK2  = 8'h55;
	localparam logic [7:0] FC_ERASE    = 8'h80;
	localparam logic [7:0] FC_CHIP     = 8'h10;
	localparam logic [7:0] FC_SECTOR   = 8'h30;
	localparam logic [7:0] FC_PROGRAM  = 8'hA0;
	localparam logic [7:0] FC_BYPASS   = 8'h20;
	localparam logic [7:0] FC_BYP_EXIT = 8'h90;
	localparam logic [7:0] FC_BYP_DONE = 8'h00;
	localparam logic [7:0] FC_RESET    = 8'hF0;
	localparam logic [7:0] FC_QUERY    = 8'h98;

	// Unlock and query addresses.
	localparam logic [UA_W-1:0] UA_555 = UA_W'(16'h0555);
	localparam logic [UA_W-1:0] UA_2AA = UA_W'(16'h02AA);
	localparam logic [UA_W-1:0] UA_055 = UA_W'(16'h0055);
	localparam logic [UA_W-1:0] UA_Q   = UA_W'(16'h0010);
	localparam logic [UA_W-1:0] UA_R   = UA_W'(16'h0011);
	localparam logic [UA_W-1:0] UA_Y   = UA_W'(16'h0012);

	// Query string bytes.
	localparam logic [7:0] CFI_Q = 8'h51;
	localparam logic [7:0] CFI_R = 8'h52;
	localparam logic [7:0] CFI_Y = 8'h59;

	localparam logic [15:0] ERASED_WORD = 16'hFFFF;

	// Command sequence phases.
	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_UNLOCK1  = 4'd1,
		PH_UNLOCK2  = 4'd2,
		PH_PROGRAM  = 4'd3,
		PH_ERASE1   = 4'd4,
		PH_ERASE2   = 4'd5,
		PH_ERASE3   = 4'd6,
		PH_BYP_IDLE = 4'd7,
		PH_BYP_PROG = 4'd8,
		PH_BYP_EXIT = 4'd9
	} phase_t;

	// Completed operation codes.
	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_PROGRAM = 3'd1,
		OP_SECTOR  = 3'd2,
		OP_CHIP    = 3'd3,
		OP_RESET   = 3'd4,
		OP_MODE    = 3'd5
	} op_t;

	// Controller states of the top level.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP
	} ctl_state_t;

	// Command decoder mode state.
	typedef struct packed {
		phase_t phase;
		logic   bypass;
		logic   query;
	} mode_t;

	// Decoder verdict for one word.
	typedef struct packed {
		mode_t      nxt;
		op_t        op;
		logic       abort;
		logic       prog;
		logic       erase_sector;
		logic       erase_chip;
		logic       use_cfi;
		logic [7:0] cfi_byte;
	} dec_t;

endpackage

FILE: rtl/nor_flash_command_interface_unit.sv
// ---------------------------------------------------------------------------
// NOR flash command interface unit
// Word-wide NOR flash with the unlock command set, array held in one RAM.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake              Ports
//   -------   --------------------   ---------------------------------------
//   request   start && !busy         cmd, word_addr, wdata
//   result    done (one cycle)       rdata, completed_op, sequence_aborted
//
// Reads, programs and command words each pass through the array RAM read
// issued at accept, then decode with read-modify-write of the same word.
// The result word shows on done in the cycle after, when the next may enter.
// Sector erase sweeps 2^SECTOR_BITS words and chip erase 2^ADDR_BITS words,
// one RAM write per cycle, with busy held high; done ends the sweep.
// After reset a clearing pass writes all 2^ADDR_BITS words to 0xFFFF, busy
// high throughout. The receiver cannot stall; busy alone gates requests.
//
module nor_flash_command_interface_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [19:0] word_addr,
	input  logic [15:0] wdata,
	output logic        done,
	output logic [15:0] rdata,
	output logic [2:0]  completed_op,
	output logic        sequence_aborted
);
	import nfci_pkg::*;

	`include "nor_flash_command_interface_unit_macros.svh"

	ctl_state_t        state_q;
	ctl_state_t        state_d;
	mode_t             mode_q;
	dec_t              dec;
	logic              accept;

	logic              cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [UA_W-1:0]   ua_q;
	logic [15:0]       wdata_q;

	logic [ADDR_W-1:0] sweep_q;
	logic              chip_q;
	logic              sweep_end;
	op_t               pend_op_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic [15:0]       mem_rdata;

	logic              fin_exec;
	logic              fin_sweep;
	logic [15:0]       exec_rdata;

	logic              done_q;
	logic [15:0]       rdata_q;
	op_t               completed_op_q;
	logic              sequence_aborted_q;

	assign accept = start && !busy;

	// Array storage; busy keeps the read at accept apart from any write back.
	nfci_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (ADDR_W'(word_addr)),
		.rdata (mem_rdata)
	);

	// Command decoding of the captured word.
	nfci_decode u_decode (
		.mode (mode_q),
		.cmd  (cmd_q),
		.ua   (ua_q),
		.code (wdata_q[7:0]),
		.dec  (dec)
	);

	// Last word of the current sweep: whole array or one sector.
	assign sweep_end = chip_q ? (&sweep_q) : (&(sweep_q & SECT_LOW_MASK) ||
		((sweep_q & SECT_LOW_MASK) == SECT_LOW_MASK));

	// Controller next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sweep_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (dec.erase_sector || dec.erase_chip) begin
					state_d = ST_SWEEP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (sweep_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Controller outputs: RAM write port and result triggers.
	always_comb begin
		busy      = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = ERASED_WORD;
		fin_exec  = 1'b0;
		fin_sweep = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_EXEC: begin
				mem_we    = dec.prog;
				mem_waddr = addr_q;
				mem_wdata = mem_rdata & wdata_q;
				fin_exec  = !(dec.erase_sector || dec.erase_chip);
			end
			ST_SWEEP: begin
				mem_we    = 1'b1;
				fin_sweep = sweep_end;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Read data of the word: array contents, query byte, or zero for writes.
	always_comb begin
		if (cmd_q == ACC_WRITE) begin
			exec_rdata = 16'h0000;
		end else if (dec.use_cfi) begin
			exec_rdata = {8'h00, dec.cfi_byte};
		end else begin
			exec_rdata = mem_rdata;
		end
	end

	// Controller and mode registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			mode_q      <= '{phase: PH_IDLE, bypass: 1'b0, query: 1'b0};
			sweep_q     <= '0;
			chip_q      <= 1'b1;
			pend_op_q   <= OP_NONE;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC) begin
				mode_q    <= dec.nxt;
				pend_op_q <= dec.op;
				chip_q    <= dec.erase_chip;
				if (dec.erase_chip) begin
					sweep_q <= '0;
				end else begin
					sweep_q <= addr_q & ~SECT_LOW_MASK;
				end
			end else if (state_q == ST_CLEAR || state_q == ST_SWEEP) begin
				sweep_q <= sweep_q + ADDR_W'(1);
			end
		end
	end

	// Captured request word.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			addr_q  <= ADDR_W'(word_addr);
			ua_q    <= UA_W'(word_addr);
			wdata_q <= wdata;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin_exec || fin_sweep;
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (fin_exec) begin
			rdata_q            <= exec_rdata;
			completed_op_q     <= dec.op;
			sequence_aborted_q <= dec.abort;
		end else if (fin_sweep) begin
			rdata_q            <= 16'h0000;
			completed_op_q     <= pend_op_q;
			sequence_aborted_q <= 1'b0;
		end
	end

	assign done             = done_q;
	assign rdata            = rdata_q;
	assign completed_op     = completed_op_q;
	assign sequence_aborted = sequence_aborted_q;

	// Checks.
	`NFCI_ASSERT_NEXT(a_accept_exec, accept, state_q == ST_EXEC, "accepted word did not execute")
	`NFCI_ASSERT_NOW(a_no_write_idle, state_q == ST_IDLE, !mem_we, "RAM write while idle")
	`NFCI_ASSERT_NOW(a_modes_excl, 1'b1, !(mode_q.bypass && mode_q.query), "bypass and query both set")
	`NFCI_ASSERT_NEXT(a_done_source, fin_exec || fin_sweep, done, "finished word not strobed")
	`NFCI_ASSERT_NOW(a_sweep_op, fin_sweep, pend_op_q == OP_SECTOR || pend_op_q == OP_CHIP, "sweep without erase")

endmodule

FILE: rtl/nfci_ram.sv
// ---------------------------------------------------------------------------
// NOR flash array memory
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module nfci_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [nfci_pkg::ADDR_W-1:0] waddr,
	input  logic [15:0]                wdata,
	input  logic                       re,
	input  logic [nfci_pkg::ADDR_W-1:0] raddr,
	output logic [15:0]                rdata
);
	import nfci_pkg::*;

	logic [15:0] mem_q [ARRAY_WORDS];
	logic [15:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/nfci_decode.sv
// ---------------------------------------------------------------------------
// NOR flash command decoder
// Unlock sequence, bypass and query mode decoding for one bus word.
// ---------------------------------------------------------------------------
module nfci_decode (
	input  nfci_pkg::mode_t        mode,
	input  logic                   cmd,
	input  logic [nfci_pkg::UA_W-1:0] ua,
	input  logic [7:0]             code,
	output nfci_pkg::dec_t         dec
);
	import nfci_pkg::*;

	always_comb begin
		dec              = '0;
		dec.nxt          = mode;
		dec.op           = OP_NONE;
		dec.abort        = 1'b0;
		dec.prog         = 1'b0;
		dec.erase_sector = 1'b0;
		dec.erase_chip   = 1'b0;
		dec.use_cfi      = 1'b0;
		dec.cfi_byte     = 8'h00;

		if (cmd == ACC_READ) begin
			// Reads never move the sequence; query mode returns the string bytes.
			if (mode.query && !mode.bypass) begin
				dec.use_cfi = 1'b1;
				if (ua == UA_Q) begin
					dec.cfi_byte = CFI_Q;
				end else if (ua == UA_R) begin
					dec.cfi_byte = CFI_R;
				end else if (ua == UA_Y) begin
					dec.cfi_byte = CFI_Y;
				end
			end
		end else if (mode.bypass) begin
			// Unlock bypass: short program and exit sequences.
			case (mode.phase)
				PH_BYP_PROG: begin
					dec.prog      = 1'b1;
					dec.op        = OP_PROGRAM;
					dec.nxt.phase = PH_BYP_IDLE;
				end
				PH_BYP_EXIT: begin
					if (code == FC_BYP_DONE) begin
						dec.nxt.bypass = 1'b0;
						dec.nxt.phase  = PH_IDLE;
						dec.op         = OP_MODE;
					end else begin
						dec.abort     = 1'b1;
						dec.nxt.phase = PH_BYP_IDLE;
					end
				end
				default: begin
					if (code == FC_PROGRAM) begin
						dec.nxt.phase = PH_BYP_PROG;
					end else if (code == FC_BYP_EXIT) begin
						dec.nxt.phase = PH_BYP_EXIT;
					end else begin
						dec.abort     = 1'b1;
						dec.nxt.phase = PH_BYP_IDLE;
					end
				end
			endcase
		end else if (mode.query) begin
			// Query mode only listens for a reset.
			if (code == FC_RESET) begin
				dec.nxt.query = 1'b0;
				dec.nxt.phase = PH_IDLE;
				dec.op        = OP_RESET;
			end
		end else if (mode.phase == PH_PROGRAM) begin
			// Program data cycle.
			dec.prog      = 1'b1;
			dec.op        = OP_PROGRAM;
			dec.nxt.phase = PH_IDLE;
		end else if (code == FC_RESET) begin
			dec.nxt.phase = PH_IDLE;
			dec.op        = OP_RESET;
		end else if (code == FC_QUERY && ua == UA_055) begin
			dec.nxt.query = 1'b1;
			dec.nxt.phase = PH_IDLE;
			dec.op        = OP_MODE;
		end else begin
			// Standard unlock sequence; any mismatch falls back to read mode.
			dec.nxt.phase = PH_IDLE;
			case (mode.phase)
				PH_IDLE: begin
					if (code == FC_UNLOCK1 && ua == UA_555) begin
						dec.nxt.phase = PH_UNLOCK1;
					end
				end
				PH_UNLOCK1: begin
					if (code == FC_UNLOCK2 && ua == UA_2AA) begin
						dec.nxt.phase = PH_UNLOCK2;
					end else begin
						dec.abort = 1'b1;
					end
				end
				PH_UNLOCK2: begin
					if (ua == UA_555 && code == FC_PROGRAM) begin
						dec.nxt.phase = PH_PROGRAM;
					end else if (ua == UA_555 && code == FC_ERASE) begin
						dec.nxt.phase = PH_ERASE1;
					end else if (ua == UA_555 && code == FC_BYPASS) begin
						dec.nxt.bypass = 1'b1;
						dec.nxt.phase  = PH_BYP_IDLE;
						dec.op         = OP_MODE;
					end else begin
						dec.abort = 1'b1;
					end
				end
				PH_ERASE1: begin
					if (code == FC_UNLOCK1 && ua == UA_555) begin
						dec.nxt.phase = PH_ERASE2;
					end else begin
						dec.abort = 1'b1;
					end
				end
				PH_ERASE2: begin
					if (code == FC_UNLOCK2 && ua == UA_2AA) begin
						dec.nxt.phase = PH_ERASE3;
					end else begin
						dec.abort = 1'b1;
					end
				end
				PH_ERASE3: begin
					if (code == FC_CHIP && ua == UA_555) begin
						dec.erase_chip = 1'b1;
						dec.op         = OP_CHIP;
					end else if (code == FC_SECTOR) begin
						dec.erase_sector = 1'b1;
						dec.op           = OP_SECTOR;
					end else begin
						dec.abort = 1'b1;
					end
				end
				default: begin
					dec.abort = 1'b1;
				end
			endcase
		end
	end

endmodule
